// ===== src/jpdt_pkg.sv =====
// jpdt_pkg: shared types and constants for the joint pd torque block
// holds the transaction structs, the limit register map and reset values
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jpdt_pkg;

    // limit register geometry
    localparam int LIM_W    = 15;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 15;

    // limit register indexes
    localparam logic [IDX_W-1:0] REG_FULL_ABAD = 3'd0;
    localparam logic [IDX_W-1:0] REG_FULL_HIP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FULL_KNEE = 3'd2;
    localparam logic [IDX_W-1:0] REG_WEAK_ABAD = 3'd3;
    localparam logic [IDX_W-1:0] REG_WEAK_HIP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_WEAK_KNEE = 3'd5;

    // limit reset values, 2^-8 Nm
    localparam logic [LIM_W-1:0] RST_FULL_ABAD = 15'd4352;
    localparam logic [LIM_W-1:0] RST_FULL_HIP  = 15'd4352;
    localparam logic [LIM_W-1:0] RST_FULL_KNEE = 15'd6656;
    localparam logic [LIM_W-1:0] RST_WEAK_ABAD = 15'd1536;
    localparam logic [LIM_W-1:0] RST_WEAK_HIP  = 15'd1536;
    localparam logic [LIM_W-1:0] RST_WEAK_KNEE = 15'd1536;

    // joint codes
    localparam logic [1:0] JOINT_ABAD = 2'd0;
    localparam logic [1:0] JOINT_HIP  = 2'd1;
    localparam logic [1:0] JOINT_KNEE = 2'd2;

    // datapath widths
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 36;
    localparam int FRAC_SH = 10;
    localparam int RAW_W   = SUM_W - FRAC_SH;

    typedef struct packed {
        logic [1:0]         leg_sel;
        logic [1:0]         joint_select;
        logic               enable;
        logic               weak_mode;
        logic signed [15:0] pos_target;
        logic signed [15:0] pos_measured;
        logic signed [15:0] vel_target;
        logic signed [15:0] vel_measured;
        logic [15:0]        stiffness;
        logic [15:0]        damping;
        logic signed [15:0] torque_ff;
    } in_t;

    typedef struct packed {
        logic [1:0]         leg_out;
        logic [1:0]         joint_out;
        logic signed [15:0] torque;
        logic               clipped;
    } out_t;

    typedef struct packed {
        logic [LIM_W-1:0] full_abad;
        logic [LIM_W-1:0] full_hip;
        logic [LIM_W-1:0] full_knee;
        logic [LIM_W-1:0] weak_abad;
        logic [LIM_W-1:0] weak_hip;
        logic [LIM_W-1:0] weak_knee;
    } limits_t;

endpackage

`default_nettype wire

// ===== src/jpdt_limit_regs.sv =====
// jpdt_limit_regs: torque limit register file with plain write port
// depends on jpdt_pkg for the register map and reset values
`timescale 1ns / 1ps
`default_nettype none

module jpdt_limit_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [jpdt_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [jpdt_pkg::DATA_W-1:0] wr_data,
    output jpdt_pkg::limits_t                limits
);

    jpdt_pkg::limits_t lim_reg;
    jpdt_pkg::limits_t lim_next;
    logic [jpdt_pkg::LIM_W-1:0] wr_val;

    assign wr_val = wr_data[jpdt_pkg::LIM_W-1:0];

    // register decode, indexes beyond the map are dropped
    always_comb
    begin
        lim_next = lim_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                jpdt_pkg::REG_FULL_ABAD: lim_next.full_abad = wr_val;
                jpdt_pkg::REG_FULL_HIP:  lim_next.full_hip  = wr_val;
                jpdt_pkg::REG_FULL_KNEE: lim_next.full_knee = wr_val;
                jpdt_pkg::REG_WEAK_ABAD: lim_next.weak_abad = wr_val;
                jpdt_pkg::REG_WEAK_HIP:  lim_next.weak_hip  = wr_val;
                jpdt_pkg::REG_WEAK_KNEE: lim_next.weak_knee = wr_val;
                default:                 lim_next = lim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.full_abad <= jpdt_pkg::RST_FULL_ABAD;
            lim_reg.full_hip  <= jpdt_pkg::RST_FULL_HIP;
            lim_reg.full_knee <= jpdt_pkg::RST_FULL_KNEE;
            lim_reg.weak_abad <= jpdt_pkg::RST_WEAK_ABAD;
            lim_reg.weak_hip  <= jpdt_pkg::RST_WEAK_HIP;
            lim_reg.weak_knee <= jpdt_pkg::RST_WEAK_KNEE;
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign limits = lim_reg;

endmodule

`default_nettype wire

// ===== src/jpdt_pipe.sv =====
// jpdt_pipe: four stage pd torque pipeline (diff, multiply, sum, clamp)
// depends on jpdt_pkg for transaction structs and datapath widths
`timescale 1ns / 1ps
`default_nettype none

module jpdt_pipe (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire jpdt_pkg::limits_t limits,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire jpdt_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output jpdt_pkg::out_t    out_data
);

    localparam int DW = jpdt_pkg::DIFF_W;
    localparam int PW = jpdt_pkg::PROD_W;
    localparam int SW = jpdt_pkg::SUM_W;
    localparam int RW = jpdt_pkg::RAW_W;
    localparam int LW = jpdt_pkg::LIM_W;

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    // stage 1: differences and selected limit
    logic [1:0]           leg1_reg, joint1_reg;
    logic signed [DW-1:0] dpos1_reg, dvel1_reg;
    logic [15:0]          kp1_reg, kd1_reg;
    logic signed [15:0]   ff1_reg;
    logic [LW-1:0]        lim1_reg;
    logic [LW-1:0]        lim1_next;

    // stage 2: products
    logic [1:0]           leg2_reg, joint2_reg;
    logic signed [PW-1:0] pp2_reg, pv2_reg;
    logic signed [15:0]   ff2_reg;
    logic [LW-1:0]        lim2_reg;

    // stage 3: raw torque
    logic [1:0]           leg3_reg, joint3_reg;
    logic signed [RW-1:0] raw3_reg;
    logic [LW-1:0]        lim3_reg;
    logic signed [SW-1:0] sum3_next;

    // stage 4: output register
    jpdt_pkg::out_t       out4_reg;
    jpdt_pkg::out_t       out4_next;
    logic signed [RW-1:0] lim_pos, lim_neg;

    // backpressure chain, a stage loads when empty or when it drains
    assign ld4 = !v4_reg || out_ready;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // limit select, disabled or unknown joint gives zero
    always_comb
    begin
        lim1_next = '0;
        if (in_data.enable)
        begin
            case (in_data.joint_select)
                jpdt_pkg::JOINT_ABAD:
                    lim1_next = in_data.weak_mode ? limits.weak_abad : limits.full_abad;
                jpdt_pkg::JOINT_HIP:
                    lim1_next = in_data.weak_mode ? limits.weak_hip : limits.full_hip;
                jpdt_pkg::JOINT_KNEE:
                    lim1_next = in_data.weak_mode ? limits.weak_knee : limits.full_knee;
                default:
                    lim1_next = '0;
            endcase
        end
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            leg1_reg   <= in_data.leg_sel;
            joint1_reg <= in_data.joint_select;
            dpos1_reg  <= DW'(in_data.pos_target) - DW'(in_data.pos_measured);
            dvel1_reg  <= DW'(in_data.vel_target) - DW'(in_data.vel_measured);
            kp1_reg    <= in_data.stiffness;
            kd1_reg    <= in_data.damping;
            ff1_reg    <= in_data.torque_ff;
            lim1_reg   <= lim1_next;
        end
    end

    // stage 2 registers, two 17x17 signed multiplies
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            leg2_reg   <= leg1_reg;
            joint2_reg <= joint1_reg;
            pp2_reg    <= PW'($signed({1'b0, kp1_reg}) * dpos1_reg);
            pv2_reg    <= PW'($signed({1'b0, kd1_reg}) * dvel1_reg);
            ff2_reg    <= ff1_reg;
            lim2_reg   <= lim1_reg;
        end
    end

    // sum at 2^-18, feed-forward aligned by the fraction shift
    assign sum3_next = SW'(pp2_reg) + SW'(pv2_reg) + (SW'(ff2_reg) <<< jpdt_pkg::FRAC_SH);

    // stage 3 registers, floor shift to 2^-8
    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            leg3_reg   <= leg2_reg;
            joint3_reg <= joint2_reg;
            raw3_reg   <= sum3_next[SW-1:jpdt_pkg::FRAC_SH];
            lim3_reg   <= lim2_reg;
        end
    end

    // symmetric clamp with clip flag
    assign lim_pos = $signed({{(RW-LW){1'b0}}, lim3_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        out4_next.leg_out   = leg3_reg;
        out4_next.joint_out = joint3_reg;
        out4_next.torque    = raw3_reg[15:0];
        out4_next.clipped   = 1'b0;
        if (raw3_reg > lim_pos)
        begin
            out4_next.torque  = lim_pos[15:0];
            out4_next.clipped = 1'b1;
        end
        else if (raw3_reg < lim_neg)
        begin
            out4_next.torque  = lim_neg[15:0];
            out4_next.clipped = 1'b1;
        end
    end

    // stage 4 output register
    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            out4_reg <= out4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out4_reg;

endmodule

`default_nettype wire

// ===== src/joint_pd_torque_with_limits_top.sv =====
// joint_pd_torque_with_limits_top: pd torque with feed-forward and limit clamp
// depends on jpdt_pkg, jpdt_limit_regs and jpdt_pipe
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   input    | in_valid / in_ready        | in_data  (jpdt_pkg::in_t)
//   output   | out_valid / out_ready      | out_data (jpdt_pkg::out_t)
//   limits   | wr_en, write only          | wr_index, wr_data[14:0]
//
// one transaction per cycle while the output is not stalled; out_valid is set through
// four register stages: difference, multiply, sum, clamp
// reset clears stage valids and loads the default torque limits
// a stalled output holds each full stage; empty stages still fill, and every stage refills as it drains
`timescale 1ns / 1ps
`default_nettype none

module joint_pd_torque_with_limits_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [jpdt_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [jpdt_pkg::DATA_W-1:0] wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire jpdt_pkg::in_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output jpdt_pkg::out_t                   out_data
);

    jpdt_pkg::limits_t limits;

    // limit register file
    jpdt_limit_regs u_limit_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .limits   (limits)
    );

    // torque pipeline
    jpdt_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .limits    (limits),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/jpdt_torque_checker.sv =====
// jpdt_torque_checker: watches the limit writes and both channels of the torque block
// predicts each clamped torque and compares it with the oldest pending prediction
// depends on jpdt_pkg
`timescale 1ns / 1ps

module jpdt_torque_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [jpdt_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [jpdt_pkg::DATA_W-1:0] wr_data,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  jpdt_pkg::in_t                    in_data,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  jpdt_pkg::out_t                   out_data,
    output int                               mismatch_count,
    output int                               pending_count
);

    // shadow of the six limit registers
    logic [jpdt_pkg::LIM_W-1:0] limit_shadow [jpdt_pkg::REG_WEAK_KNEE+1];

    // predicted torque results, oldest first
    jpdt_pkg::out_t torque_queue [$];

    // pd sum at 2^-18, floor shift to 2^-8, symmetric clamp
    function automatic jpdt_pkg::out_t pd_torque_predict(input jpdt_pkg::in_t cmd);
        longint pos_err;
        longint vel_err;
        longint acc;
        longint raw;
        longint lim;
        jpdt_pkg::out_t res;
        pos_err = longint'(cmd.pos_target) - longint'(cmd.pos_measured);
        vel_err = longint'(cmd.vel_target) - longint'(cmd.vel_measured);
        acc = longint'(cmd.stiffness) * pos_err + longint'(cmd.damping) * vel_err
            + longint'(cmd.torque_ff) * 1024;
        raw = acc >>> jpdt_pkg::FRAC_SH;
        lim = 0;
        if (cmd.enable && cmd.joint_select <= jpdt_pkg::JOINT_KNEE)
            lim = longint'(limit_shadow[(cmd.weak_mode ? jpdt_pkg::REG_WEAK_ABAD
                                                       : jpdt_pkg::REG_FULL_ABAD)
                                        + cmd.joint_select]);
        res.leg_out   = cmd.leg_sel;
        res.joint_out = cmd.joint_select;
        res.clipped   = 1'b0;
        if (raw > lim) begin
            raw         = lim;
            res.clipped = 1'b1;
        end
        else if (raw < -lim) begin
            raw         = -lim;
            res.clipped = 1'b1;
        end
        res.torque = raw[15:0];
        return res;
    endfunction

    task automatic note_mismatch(input string what, input jpdt_pkg::out_t want,
                                 input jpdt_pkg::out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: exp leg %0d joint %0d torque %0d clip %0d, %s",
                     $time, what, want.leg_out, want.joint_out, want.torque, want.clipped,
                     $sformatf("got leg %0d joint %0d torque %0d clip %0d",
                               got.leg_out, got.joint_out, got.torque, got.clipped));
    endtask

    // track writes, check results, then queue new predictions
    always @(posedge clk or negedge rst_n)
    begin
        jpdt_pkg::out_t want;
        if (!rst_n)
        begin
            limit_shadow[jpdt_pkg::REG_FULL_ABAD] = jpdt_pkg::RST_FULL_ABAD;
            limit_shadow[jpdt_pkg::REG_FULL_HIP]  = jpdt_pkg::RST_FULL_HIP;
            limit_shadow[jpdt_pkg::REG_FULL_KNEE] = jpdt_pkg::RST_FULL_KNEE;
            limit_shadow[jpdt_pkg::REG_WEAK_ABAD] = jpdt_pkg::RST_WEAK_ABAD;
            limit_shadow[jpdt_pkg::REG_WEAK_HIP]  = jpdt_pkg::RST_WEAK_HIP;
            limit_shadow[jpdt_pkg::REG_WEAK_KNEE] = jpdt_pkg::RST_WEAK_KNEE;
            torque_queue.delete();
            pending_count = 0;
        end
        else
        begin
            // out-of-range indexes are dropped
            if (wr_en && wr_index <= jpdt_pkg::REG_WEAK_KNEE)
                limit_shadow[wr_index] = wr_data[jpdt_pkg::LIM_W-1:0];

            // result transaction
            if (out_valid && out_ready)
            begin
                if (torque_queue.size() == 0)
                    note_mismatch("unexpected result", '0, out_data);
                else
                begin
                    want = torque_queue.pop_front();
                    if (out_data.leg_out   !== want.leg_out   ||
                        out_data.joint_out !== want.joint_out ||
                        out_data.torque    !== want.torque    ||
                        out_data.clipped   !== want.clipped)
                        note_mismatch("result mismatch", want, out_data);
                end
            end

            // command transaction
            if (in_valid && in_ready)
                torque_queue.push_back(pd_torque_predict(in_data));

            pending_count = torque_queue.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for joint_pd_torque_with_limits_top
// drives limit writes and joint commands with random idling on both channels
// depends on jpdt_pkg, joint_pd_torque_with_limits_top and jpdt_torque_checker
`timescale 1ns / 1ps

module tb;

    // no joint has this code
    localparam logic [1:0] JOINT_UNUSED = 2'd3;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          wr_en     = 1'b0;
    logic [jpdt_pkg::IDX_W-1:0]    wr_index  = '0;
    logic [jpdt_pkg::DATA_W-1:0]   wr_data   = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    jpdt_pkg::in_t                 in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    jpdt_pkg::out_t                out_data;
    int                            mismatch_count;
    int                            pending_count;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // limits as last written, used to aim commands at the clamp edges
    int limit_now [jpdt_pkg::REG_WEAK_KNEE+1] = '{
        int'(jpdt_pkg::RST_FULL_ABAD), int'(jpdt_pkg::RST_FULL_HIP),
        int'(jpdt_pkg::RST_FULL_KNEE), int'(jpdt_pkg::RST_WEAK_ABAD),
        int'(jpdt_pkg::RST_WEAK_HIP),  int'(jpdt_pkg::RST_WEAK_KNEE)};

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    joint_pd_torque_with_limits_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    jpdt_torque_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_stall_pct);

    function automatic jpdt_pkg::in_t mk_cmd(input int leg, input logic [1:0] joint,
                                             input logic en, input logic weak_sel,
                                             input int pt, input int pm, input int vt,
                                             input int vm, input int kp, input int kd,
                                             input int ff);
        jpdt_pkg::in_t c;
        c.leg_sel      = leg[1:0];
        c.joint_select = joint;
        c.enable       = en;
        c.weak_mode    = weak_sel;
        c.pos_target   = pt[15:0];
        c.pos_measured = pm[15:0];
        c.vel_target   = vt[15:0];
        c.vel_measured = vm[15:0];
        c.stiffness    = kp[15:0];
        c.damping      = kd[15:0];
        c.torque_ff    = ff[15:0];
        return c;
    endfunction

    function automatic int active_limit(input jpdt_pkg::in_t c);
        if (c.enable && c.joint_select <= jpdt_pkg::JOINT_KNEE)
            return limit_now[(c.weak_mode ? jpdt_pkg::REG_WEAK_ABAD : jpdt_pkg::REG_FULL_ABAD)
                             + c.joint_select];
        return 0;
    endfunction

    // random command: full random, small-signal, clamp edge or small errors with random gains
    function automatic jpdt_pkg::in_t rand_cmd();
        jpdt_pkg::in_t c;
        int  kind;
        int  ff;
        kind = $urandom_range(99);
        c = jpdt_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        c.joint_select = ($urandom_range(9) == 0) ? JOINT_UNUSED : 2'($urandom_range(2));
        c.enable       = ($urandom_range(9) != 0);
        if (kind < 25)
            return c;
        if (kind < 60)
        begin
            c.stiffness    = 16'($urandom_range(63));
            c.damping      = 16'($urandom_range(1023));
            c.pos_measured = c.pos_target + 16'($urandom_range(400)) - 16'd200;
            c.vel_measured = c.vel_target + 16'($urandom_range(400)) - 16'd200;
            c.torque_ff    = 16'($urandom_range(2000)) - 16'd1000;
        end
        else if (kind < 85)
        begin
            if ($urandom_range(1))
            begin
                c.pos_measured = c.pos_target;
                c.vel_measured = c.vel_target;
            end
            else
            begin
                c.stiffness = '0;
                c.damping   = '0;
            end
            ff = active_limit(c) + int'($urandom_range(4)) - 2;
            if ($urandom_range(1))
                ff = -ff;
            if (ff > 32767)
                ff = 32767;
            if (ff < -32768)
                ff = -32768;
            c.torque_ff = ff[15:0];
        end
        else
        begin
            c.pos_measured = c.pos_target + 16'($urandom_range(16)) - 16'd8;
            c.vel_measured = c.vel_target + 16'($urandom_range(16)) - 16'd8;
        end
        return c;
    endfunction

    // one command transaction, with random idle cycles ahead of it
    task automatic send_cmd(input jpdt_pkg::in_t cmd);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // all six limits plus the two unused indexes
    task automatic write_limits(input int mode);
        logic [jpdt_pkg::DATA_W-1:0] val;
        for (int r = 0; r <= 7; r++)
        begin
            case (mode)
                0:       val = r[0] ? 15'h7FFF : 15'h4000;
                1:       val = r[0] ? 15'h0001 : 15'h0000;
                2:       val = 15'($urandom);
                default: val = 15'($urandom_range(200));
            endcase
            if (r > jpdt_pkg::REG_WEAK_KNEE)
                val = 15'($urandom);
            else
                limit_now[r] = int'(val[jpdt_pkg::LIM_W-1:0]);
            wr_en    <= 1'b1;
            wr_index <= r[jpdt_pkg::IDX_W-1:0];
            wr_data  <= val;
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (8) @(posedge clk);
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands under the reset limits
        tx_idle_pct  = 18;
        rx_stall_pct = 79;
        send_cmd(mk_cmd(0, jpdt_pkg::JOINT_ABAD, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(1, jpdt_pkg::JOINT_KNEE, 1, 0, 32767, -32768, 32767, -32768,
                        65535, 65535, 32767));
        send_cmd(mk_cmd(2, jpdt_pkg::JOINT_HIP, 1, 0, -32768, 32767, -32768, 32767,
                        65535, 65535, -32768));
        send_cmd(mk_cmd(3, jpdt_pkg::JOINT_HIP, 0, 0, 0, 0, 0, 0, 0, 0, 100));
        send_cmd(mk_cmd(0, jpdt_pkg::JOINT_KNEE, 0, 1, 5, 5, 7, 7, 999, 999, 0));
        send_cmd(mk_cmd(1, JOINT_UNUSED, 1, 0, 0, 0, 0, 0, 0, 0, -50));
        send_cmd(mk_cmd(2, JOINT_UNUSED, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(0, jpdt_pkg::JOINT_ABAD, 1, 0, 0, 0, 0, 0, 0, 0, 4352));
        send_cmd(mk_cmd(1, jpdt_pkg::JOINT_ABAD, 1, 0, 0, 0, 0, 0, 0, 0, 4353));
        send_cmd(mk_cmd(2, jpdt_pkg::JOINT_HIP, 1, 0, 0, 0, 0, 0, 0, 0, -4352));
        send_cmd(mk_cmd(3, jpdt_pkg::JOINT_HIP, 1, 0, 0, 0, 0, 0, 0, 0, -4353));
        send_cmd(mk_cmd(0, jpdt_pkg::JOINT_KNEE, 1, 0, 0, 0, 0, 0, 0, 0, 6656));
        send_cmd(mk_cmd(1, jpdt_pkg::JOINT_KNEE, 1, 0, 0, 0, 0, 0, 0, 0, 6657));
        send_cmd(mk_cmd(2, jpdt_pkg::JOINT_ABAD, 1, 1, 0, 0, 0, 0, 0, 0, 1537));
        send_cmd(mk_cmd(3, jpdt_pkg::JOINT_HIP, 1, 1, 0, 0, 0, 0, 0, 0, -1536));
        send_cmd(mk_cmd(0, jpdt_pkg::JOINT_KNEE, 1, 1, 0, 0, 0, 0, 0, 0, -1537));
        // floor of the shift: small sums around zero round down
        send_cmd(mk_cmd(1, jpdt_pkg::JOINT_HIP, 1, 0, 0, 1, 0, 0, 1, 0, 0));
        send_cmd(mk_cmd(2, jpdt_pkg::JOINT_HIP, 1, 0, 0, 0, 1, 0, 0, 1023, 0));
        send_cmd(mk_cmd(3, jpdt_pkg::JOINT_ABAD, 1, 0, 1, 0, 0, 0, 1024, 0, -1));
        send_cmd(mk_cmd(3, jpdt_pkg::JOINT_ABAD, 0, 1, 0, 0, 0, 0, 0, 0, -32768));
        send_cmd(mk_cmd(0, jpdt_pkg::JOINT_KNEE, 1, 1, 0, 0, 32767, -32768, 0, 65535, 0));
        wait_drained();

        // random commands over several limit settings and idle patterns
        for (int s = 0; s < 6; s++)
        begin
            write_limits(s % 4);
            for (int p = 0; p < 3; p++)
            begin
                tx_idle_pct  = (p == 0) ? 18 : (p == 1) ? 79 : 0;
                rx_stall_pct = (p == 0) ? 79 : (p == 1) ? 18 : 0;
                repeat (80)
                    send_cmd(rand_cmd());
            end
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
